>>> hdl/crc_codeword_generator_core_macros.svh
// Assertion macros shared by the RTL of the CRC codeword generator.
`ifndef CRC_CODEWORD_GENERATOR_CORE_MACROS_SVH
`define CRC_CODEWORD_GENERATOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CCG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CCG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/ccg_pkg.sv
`default_nettype none

package ccg_pkg;

   localparam int MSG_BITS          = 32;
   localparam int LEN_BITS          = 6;
   localparam int REM_BITS          = 31;
   localparam int DEG_BITS          = 5;
   localparam int CODEWORD_BITS_DEF = 32;
   localparam int STEP_BITS         = 8;
   localparam int CRC_STAGES        = MSG_BITS / STEP_BITS;

   typedef logic [MSG_BITS-1:0]  word_type;
   typedef logic [DEG_BITS-1:0]  deg_type;
   typedef logic [LEN_BITS-1:0]  len_type;
   typedef logic [REM_BITS-1:0]  rem_type;
   typedef logic [STEP_BITS-1:0] chunk_type;

   localparam word_type POLY_RESET = word_type'(11);

   function automatic deg_type top_index(word_type p);
      deg_type d;
      d = '0;
      for (int i = 0; i < MSG_BITS; i++) begin
         if (p[i]) begin
            d = DEG_BITS'(i);
         end
      end
      return d;
   endfunction

   // Moves the top term of the polynomial just above the MSB, so that the lower
   // terms line up with a top-aligned remainder whatever the degree.
   function automatic word_type align_poly(word_type p);
      word_type g;
      g = p << ((DEG_BITS+1)'(MSG_BITS) - {1'b0, top_index(p)});
      return g;
   endfunction

   function automatic word_type crc_steps(word_type r, chunk_type b, word_type g);
      word_type acc;
      logic     fb;
      acc = r;
      for (int i = STEP_BITS - 1; i >= 0; i--) begin
         fb  = b[i] ^ acc[MSG_BITS-1];
         acc = acc << 1;
         if (fb) begin
            acc = acc ^ g;
         end
      end
      return acc;
   endfunction

endpackage

`default_nettype wire

>>> hdl/crc_codeword_generator_core.sv
// CRC codeword generator with a programmable generator polynomial. Each request
// beat carries a right-aligned message and its length; the response beat carries
// the GF(2) remainder of the message with degree zero bits appended, the codeword
// (message shifted up by the degree, remainder in the low bits) and an error flag
// that is set, with zero data, for a zero polynomial, a length outside 1 to 32,
// or a message that does not fit the codeword together with the remainder. The
// degree is the index of the top set bit of the polynomial. The block is a
// six-stage pipeline: one capture stage, four division stages of eight bits each,
// and one output alignment stage. It takes one beat per cycle and each beat passes
// through the stages in that order; a stall on the response side holds the
// whole pipeline. Write the polynomial only while no beat is in flight.
`default_nettype none

`include "crc_codeword_generator_core_macros.svh"

module crc_codeword_generator_core #(
   parameter int CODEWORD_BITS = ccg_pkg::CODEWORD_BITS_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    csr_wr_en,
   input  wire ccg_pkg::word_type csr_wr_data,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire ccg_pkg::word_type req_message_bits,
   input  wire ccg_pkg::len_type  req_message_length,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output ccg_pkg::word_type      rsp_codeword,
   output ccg_pkg::rem_type       rsp_crc_remainder,
   output logic                   rsp_error_flag
);
   import ccg_pkg::*;

   localparam int LAST = CRC_STAGES;

   word_type poly_ff, poly_in;
   word_type galign_ff, galign_in;
   deg_type  deg_ff, deg_in;
   logic     poly_zero_ff, poly_zero_in;

   logic     vld_ff [LAST+1];
   logic     vld_in [LAST+1];
   logic     err_ff [LAST+1];
   logic     err_in [LAST+1];
   word_type msg_ff [LAST+1];
   word_type msg_in [LAST+1];
   word_type rem_ff [LAST+1];
   word_type rem_in [LAST+1];

   logic     rsp_valid_ff, rsp_valid_in;
   word_type rsp_code_ff, rsp_code_in;
   rem_type  rsp_rem_ff, rsp_rem_in;
   logic     rsp_err_ff, rsp_err_in;

   logic     advance;
   logic     bad_len;
   logic [7:0] fit_sum;
   rem_type  rem_out;
   word_type code_out;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      poly_in      = poly_ff;
      galign_in    = galign_ff;
      deg_in       = deg_ff;
      poly_zero_in = poly_zero_ff;
      if (csr_wr_en) begin
         poly_in      = csr_wr_data;
         galign_in    = align_poly(csr_wr_data);
         deg_in       = top_index(csr_wr_data);
         poly_zero_in = (csr_wr_data == '0);
      end
   end

   always_comb begin
      fit_sum = {2'b00, req_message_length} + {3'b000, deg_ff};
      bad_len = (req_message_length == '0) || (req_message_length > LEN_BITS'(MSG_BITS))
                || (fit_sum > 8'(CODEWORD_BITS));
      vld_in[0] = req_valid;
      err_in[0] = poly_zero_ff || bad_len;
      msg_in[0] = req_message_bits & ~(word_type'('1) << req_message_length);
      rem_in[0] = '0;
      for (int k = 1; k <= LAST; k++) begin
         vld_in[k] = vld_ff[k-1];
         err_in[k] = err_ff[k-1];
         msg_in[k] = msg_ff[k-1];
         rem_in[k] = crc_steps(rem_ff[k-1],
                               msg_ff[k-1][MSG_BITS-1-(k-1)*STEP_BITS -: STEP_BITS],
                               galign_ff);
      end
   end

   always_comb begin
      rem_out  = REM_BITS'(rem_ff[LAST] >> (LEN_BITS'(MSG_BITS) - {1'b0, deg_ff}));
      code_out = (msg_ff[LAST] << deg_ff) | {1'b0, rem_out};
      rsp_valid_in = vld_ff[LAST];
      rsp_err_in   = err_ff[LAST];
      rsp_code_in  = err_ff[LAST] ? '0 : code_out;
      rsp_rem_in   = err_ff[LAST] ? '0 : rem_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff      <= POLY_RESET;
         galign_ff    <= align_poly(POLY_RESET);
         deg_ff       <= top_index(POLY_RESET);
         poly_zero_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k <= LAST; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         poly_ff      <= poly_in;
         galign_ff    <= galign_in;
         deg_ff       <= deg_in;
         poly_zero_ff <= poly_zero_in;
         if (advance) begin
            rsp_valid_ff <= rsp_valid_in;
            for (int k = 0; k <= LAST; k++) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_code_ff <= rsp_code_in;
         rsp_rem_ff  <= rsp_rem_in;
         rsp_err_ff  <= rsp_err_in;
         for (int k = 0; k <= LAST; k++) begin
            err_ff[k] <= err_in[k];
            msg_ff[k] <= msg_in[k];
            rem_ff[k] <= rem_in[k];
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_codeword      = rsp_code_ff;
   assign rsp_crc_remainder = rsp_rem_ff;
   assign rsp_error_flag    = rsp_err_ff;

   `CCG_ASSERT_SAME(a_err_zero, clock, reset, rsp_valid && rsp_error_flag, (rsp_codeword == '0) && (rsp_crc_remainder == '0), "Rejected beat carries nonzero data.")
   `CCG_ASSERT_SAME(a_rem_fits, clock, reset, rsp_valid && !rsp_error_flag, (rsp_crc_remainder >> deg_ff) == '0, "Remainder is wider than the degree.")
   `CCG_ASSERT_SAME(a_code_low, clock, reset, rsp_valid && !rsp_error_flag, ((rsp_codeword ^ {1'b0, rsp_crc_remainder}) << (LEN_BITS'(MSG_BITS) - {1'b0, deg_ff})) == '0, "Codeword low bits differ from the remainder.")
   `CCG_ASSERT_NEXT(a_zero_poly, clock, reset, req_valid && !req_stall && poly_zero_ff, err_ff[0], "Zero polynomial did not flag an error.")

endmodule

`default_nettype wire

>>> dv/crc_codeword_generator_checker.sv
module crc_codeword_generator_checker #(
   parameter int CODEWORD_BITS = ccg_pkg::CODEWORD_BITS_DEF
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               csr_wr_en,
   input  ccg_pkg::word_type csr_wr_data,
   input  wire               req_valid,
   input  wire               req_stall,
   input  ccg_pkg::word_type req_message_bits,
   input  ccg_pkg::len_type  req_message_length,
   input  wire               rsp_valid,
   input  wire               rsp_stall,
   input  ccg_pkg::word_type rsp_codeword,
   input  ccg_pkg::rem_type  rsp_crc_remainder,
   input  wire               rsp_error_flag,
   output int                error_count,
   output int                pending_count
);
   import ccg_pkg::*;

   typedef struct packed {
      word_type codeword;
      rem_type  remainder;
      logic     error;
   } codeword_result_type;

   word_type            generator_poly = POLY_RESET;
   codeword_result_type expected_codewords[$];

   function automatic codeword_result_type compute_codeword(input word_type poly,
                                                            input word_type msg,
                                                            input len_type len);
      codeword_result_type r;
      int                  degree;
      logic [63:0]         data;
      logic [63:0]         work;
      r = '0;
      r.error = 1'b1;
      degree = -1;
      for (int i = 0; i < MSG_BITS; i++) begin
         if (poly[i]) begin
            degree = i;
         end
      end
      if (degree < 0 || len == 0 || len > 32) begin
         return r;
      end
      if (int'(len) + degree > CODEWORD_BITS) begin
         return r;
      end
      data = 64'(msg);
      if (len < 32) begin
         data = data & ((64'd1 << len) - 64'd1);
      end
      work = data << degree;
      for (int i = int'(len) + degree - 1; i >= degree; i--) begin
         if (work[i]) begin
            work = work ^ (64'(poly) << (i - degree));
         end
      end
      work = work & ((64'd1 << degree) - 64'd1);
      r.remainder = rem_type'(work);
      r.codeword  = word_type'((data << degree) | work);
      r.error     = 1'b0;
      return r;
   endfunction

   task automatic flag_error(input string what);
      begin
         error_count++;
         if (error_count <= 10) begin
            $display("%0t: %s", $realtime, what);
         end
      end
   endtask

   always @(posedge clock) begin
      codeword_result_type want;
      if (reset) begin
         generator_poly = POLY_RESET;
         expected_codewords.delete();
      end else begin
         if (csr_wr_en) begin
            generator_poly = csr_wr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_codewords.size() == 0) begin
               flag_error($sformatf("unexpected result beat: codeword %h remainder %h error %b",
                                    rsp_codeword, rsp_crc_remainder, rsp_error_flag));
            end else begin
               want = expected_codewords.pop_front();
               if (rsp_codeword !== want.codeword || rsp_crc_remainder !== want.remainder ||
                   rsp_error_flag !== want.error) begin
                  flag_error($sformatf({"mismatch: codeword exp %h got %h, remainder exp %h ",
                                        "got %h, error exp %b got %b"},
                                       want.codeword, rsp_codeword, want.remainder,
                                       rsp_crc_remainder, want.error, rsp_error_flag));
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_codewords.push_back(compute_codeword(generator_poly, req_message_bits,
                                                          req_message_length));
         end
      end
      pending_count = expected_codewords.size();
   end

endmodule

>>> dv/crc_codeword_generator_core_tb.sv
module crc_codeword_generator_core_tb;
   import ccg_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 200;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     csr_wr_en = 1'b0;
   word_type csr_wr_data = '0;
   logic     req_valid = 1'b0;
   logic     req_stall;
   word_type req_message_bits = '0;
   len_type  req_message_length = len_type'(1);
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   word_type rsp_codeword;
   rem_type  rsp_crc_remainder;
   logic     rsp_error_flag;

   int checker_errors;
   int checker_pending;
   int cycle_count = 0;
   int tx_idle_pct = 28;
   int rx_idle_pct = 73;
   int hold_seq = 0;
   int poly_degree = 3;

   crc_codeword_generator_core dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_message_bits   (req_message_bits),
      .req_message_length (req_message_length),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_codeword       (rsp_codeword),
      .rsp_crc_remainder  (rsp_crc_remainder),
      .rsp_error_flag     (rsp_error_flag)
   );

   crc_codeword_generator_checker chk (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_message_bits   (req_message_bits),
      .req_message_length (req_message_length),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_codeword       (rsp_codeword),
      .rsp_crc_remainder  (rsp_crc_remainder),
      .rsp_error_flag     (rsp_error_flag),
      .error_count        (checker_errors),
      .pending_count      (checker_pending)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // The receiver stalls at random, and holds off for a long stretch on request so that
   // the pipeline fills while the sender keeps offering beats.
   initial begin
      int hold_seen;
      hold_seen = 0;
      forever begin
         @(posedge clock);
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
         end
      end
   end

   task automatic send_message(input word_type msg, input len_type len);
      begin
         while ($urandom_range(0, 99) < tx_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid          <= 1'b1;
         req_message_bits   <= msg;
         req_message_length <= len;
         @(posedge clock);
         while (req_stall) begin
            @(posedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      begin
         req_valid <= 1'b0;
         do begin
            @(posedge clock);
         end while (checker_pending != 0);
      end
   endtask

   task automatic write_poly(input word_type value);
      begin
         wait_drained();
         csr_wr_en   <= 1'b1;
         csr_wr_data <= value;
         @(posedge clock);
         csr_wr_en <= 1'b0;
         poly_degree = -1;
         for (int i = 0; i < MSG_BITS; i++) begin
            if (value[i]) begin
               poly_degree = i;
            end
         end
      end
   endtask

   initial begin
      word_type poly_choice;
      int       pick;
      int       deg_pick;
      int       max_len;
      len_type  len_pick;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_message(32'h0000_0000, len_type'(1));
      send_message(32'h0000_0001, len_type'(1));
      send_message(32'hFFFF_FFFF, len_type'(29));
      send_message(32'hFFFF_FFFF, len_type'(30));
      send_message(32'h1234_5678, len_type'(32));
      send_message(32'hFFFF_FFFF, len_type'(0));
      send_message(32'h0000_0005, len_type'(33));
      send_message(32'hFFFF_FFFF, len_type'(63));
      send_message(32'hFFFF_FFF5, len_type'(4));
      send_message(32'h0001_ABCD, len_type'(17));

      write_poly(32'h0000_0000);
      send_message(32'hFFFF_FFFF, len_type'(8));
      send_message(32'h0000_0001, len_type'(32));

      write_poly(32'h0000_0001);
      send_message(32'hFFFF_FFFF, len_type'(32));
      send_message(32'h8000_0000, len_type'(32));
      send_message(32'h0000_0000, len_type'(1));

      write_poly(32'hFFFF_FFFF);
      send_message(32'h0000_0001, len_type'(1));
      send_message(32'h0000_0000, len_type'(1));
      send_message(32'h0000_0001, len_type'(2));

      write_poly(32'h8000_0000);
      send_message(32'h0000_0001, len_type'(1));
      send_message(32'hFFFF_FFFE, len_type'(1));

      write_poly(32'h04C1_1DB7);
      send_message(32'h0000_003F, len_type'(6));
      send_message(32'h0000_002A, len_type'(6));
      send_message(32'h0000_007F, len_type'(7));

      for (int blk = 0; blk < 15; blk++) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0: poly_choice = '0;
            1: poly_choice = word_type'(1);
            2: poly_choice = '1;
            3: poly_choice = word_type'($urandom);
            default: begin
               deg_pick    = $urandom_range(1, (pick == 4) ? 31 : 16);
               poly_choice = (word_type'($urandom) & ((word_type'(1) << deg_pick) - 1)) |
                             (word_type'(1) << deg_pick);
            end
         endcase
         write_poly(poly_choice);
         case (blk / 5)
            0: begin
               tx_idle_pct = 28;
               rx_idle_pct = 73;
            end
            1: begin
               tx_idle_pct = 73;
               rx_idle_pct = 28;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         if (blk == 10) begin
            hold_seq <= hold_seq + 1;
         end
         max_len = (poly_degree < 0) ? 32 : 32 - poly_degree;
         for (int n = 0; n < 50; n++) begin
            if ($urandom_range(0, 99) < 85) begin
               len_pick = len_type'($urandom_range(1, max_len));
            end else begin
               len_pick = len_type'($urandom_range(0, 63));
            end
            send_message(word_type'($urandom), len_pick);
         end
      end

      wait_drained();
      repeat (16) @(posedge clock);
      if (checker_errors == 0 && checker_pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/ccg_pkg.sv
hdl/crc_codeword_generator_core.sv
dv/crc_codeword_generator_checker.sv
dv/crc_codeword_generator_core_tb.sv
